>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VCCB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VCCB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/vccb_pkg.sv
`default_nettype none

package vccb_pkg;

  // Geometry and fixed point format
  localparam int DIM_BITS  = 10;
  localparam int FRAC_BITS = 8;
  localparam int SIZE_W    = DIM_BITS + 1;
  localparam int IDX_W     = 30;
  localparam int SUM_W     = 40;
  localparam int CNT_W     = 31;
  localparam int CENT_W    = DIM_BITS + FRAC_BITS;
  localparam int SLICE_W   = 2 * DIM_BITS + 1;
  localparam int REM_W     = 2 * DIM_BITS;

  // Shared divider geometry: widest dividend is sum << FRAC_BITS
  localparam int DIV_W  = SUM_W + FRAC_BITS;
  localparam int DIV_RW = (CNT_W > SLICE_W) ? CNT_W : SLICE_W;
  localparam int STEP_W = $clog2(DIV_W + 1);

  // Stream and config port widths
  localparam int CFG_IDX_W = 2;
  localparam int S_DATA_W  = ((IDX_W + 7) / 8) * 8;
  localparam int M_RAW_W   = 3 * CENT_W + 6 * DIM_BITS;
  localparam int M_DATA_W  = ((M_RAW_W + 7) / 8) * 8;

  localparam logic [SIZE_W-1:0] SIZE_FULL = {1'b1, {DIM_BITS{1'b0}}};
  localparam logic [CENT_W-1:0] CENT_MAX  = {CENT_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_Y = 2'd0,
    REG_SIZE_X = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GO,
    ST_WAIT,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  // Which division the shared unit is running
  typedef enum logic [2:0] {
    OP_Z,
    OP_X,
    OP_CY,
    OP_CX,
    OP_CZ
  } op_e;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;  // left aligned
    logic [DIV_RW-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] y;
    logic [DIM_BITS-1:0] x;
    logic [DIM_BITS-1:0] z;
  } coord_t;

  typedef struct packed {
    logic [SIZE_W-1:0] y;
    logic [SIZE_W-1:0] x;
    logic [SIZE_W-1:0] z;
  } sizes_t;

  typedef struct packed {
    logic update;
    logic restart;
  } acc_ctl_t;

  typedef struct packed {
    logic [SUM_W-1:0]    sum_y;
    logic [SUM_W-1:0]    sum_x;
    logic [SUM_W-1:0]    sum_z;
    logic [CNT_W-1:0]    count;
    logic [SIZE_W-1:0]   min_y;
    logic [SIZE_W-1:0]   min_x;
    logic [SIZE_W-1:0]   min_z;
    logic [DIM_BITS-1:0] max_y;
    logic [DIM_BITS-1:0] max_x;
    logic [DIM_BITS-1:0] max_z;
  } acc_state_t;

  // Zero acts as one, anything above full size acts as full size
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_FULL) begin
      r = SIZE_FULL;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Saturating coordinate accumulate
  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] s,
                                               input logic [DIM_BITS-1:0] c);
    logic [SUM_W:0] ext;
    ext = {1'b0, s} + (SUM_W + 1)'(c);
    return ext[SUM_W] ? SUM_MAX : ext[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/vccb_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// The dividend arrives left aligned; once all 'steps' iterations are done the quotient sits
// in the low bits of quot_o and the remainder in rem_o.
module vccb_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vccb_pkg::div_req_t            req_i,
  output logic                          done_o,
  output logic [vccb_pkg::DIV_W-1:0]    quot_o,
  output logic [vccb_pkg::DIV_RW-1:0]   rem_o
);

  logic [vccb_pkg::DIV_W-1:0]  quot_q, quot_d;
  logic [vccb_pkg::DIV_RW-1:0] rem_q, rem_d;
  logic [vccb_pkg::DIV_RW-1:0] dvs_q, dvs_d;
  logic [vccb_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;

  logic [vccb_pkg::DIV_RW:0]   trial;
  logic [vccb_pkg::DIV_RW:0]   diff;
  logic                        fits;

  // One trial subtract per cycle
  always_comb begin
    trial = {rem_q, quot_q[vccb_pkg::DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
  end

  // Next state of the iteration
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[vccb_pkg::DIV_W-2:0], fits};
      rem_d  = fits ? diff[vccb_pkg::DIV_RW-1:0] : trial[vccb_pkg::DIV_RW-1:0];
      cnt_d  = cnt_q - vccb_pkg::STEP_W'(1);
      if (cnt_q == vccb_pkg::STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath flops
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> rtl/core/vccb_acc.sv
`default_nettype none

// Region accumulators: saturating sums, count and per-axis bounds.
module vccb_acc (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  vccb_pkg::acc_ctl_t      ctl_i,
  input  vccb_pkg::coord_t        coord_i,
  input  vccb_pkg::sizes_t        sizes_i,   // effective sizes, for restart
  output vccb_pkg::acc_state_t    acc_o
);

  vccb_pkg::acc_state_t acc_q, acc_d;

  always_comb begin
    acc_d = acc_q;
    priority if (ctl_i.restart) begin
      acc_d.sum_y = '0;
      acc_d.sum_x = '0;
      acc_d.sum_z = '0;
      acc_d.count = '0;
      acc_d.min_y = sizes_i.y;
      acc_d.min_x = sizes_i.x;
      acc_d.min_z = sizes_i.z;
      acc_d.max_y = '0;
      acc_d.max_x = '0;
      acc_d.max_z = '0;
    end else if (ctl_i.update) begin
      acc_d.sum_y = vccb_pkg::sat_sum(acc_q.sum_y, coord_i.y);
      acc_d.sum_x = vccb_pkg::sat_sum(acc_q.sum_x, coord_i.x);
      acc_d.sum_z = vccb_pkg::sat_sum(acc_q.sum_z, coord_i.z);
      if (acc_q.count != vccb_pkg::CNT_MAX) begin
        acc_d.count = acc_q.count + vccb_pkg::CNT_W'(1);
      end
      // Bounds
      if (vccb_pkg::SIZE_W'(coord_i.y) < acc_q.min_y) acc_d.min_y = vccb_pkg::SIZE_W'(coord_i.y);
      if (vccb_pkg::SIZE_W'(coord_i.x) < acc_q.min_x) acc_d.min_x = vccb_pkg::SIZE_W'(coord_i.x);
      if (vccb_pkg::SIZE_W'(coord_i.z) < acc_q.min_z) acc_d.min_z = vccb_pkg::SIZE_W'(coord_i.z);
      if (coord_i.y > acc_q.max_y) acc_d.max_y = coord_i.y;
      if (coord_i.x > acc_q.max_x) acc_d.max_x = coord_i.x;
      if (coord_i.z > acc_q.max_z) acc_d.max_z = coord_i.z;
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q.sum_y <= '0;
      acc_q.sum_x <= '0;
      acc_q.sum_z <= '0;
      acc_q.count <= '0;
      acc_q.min_y <= vccb_pkg::SIZE_FULL;
      acc_q.min_x <= vccb_pkg::SIZE_FULL;
      acc_q.min_z <= vccb_pkg::SIZE_FULL;
      acc_q.max_y <= '0;
      acc_q.max_x <= '0;
      acc_q.max_z <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

>>> rtl/core/voxel_centroid_bounding_box_core.sv
// One voxel is taken at a time, and the next only once the last one is through;
// the voxel that closes a region also computes the centroids, whose result then
// sits in the output register. All divisions share the single bit-serial
// divider: 30 steps for z, 20 for x and y, and 48 for each of the three
// centroids. Reset (async, active low) sets all sizes to full extent, clears
// the region and leaves the output empty.
`default_nettype none

module voxel_centroid_bounding_box_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vccb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vccb_pkg::SIZE_W-1:0]         cfg_data_i,
  // Voxel stream in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [vccb_pkg::S_DATA_W-1:0]       s_axis_tdata,   // [29:0] voxel_index
  input  logic                                s_axis_tlast,   // last_voxel
  // Region result stream out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // from bit 0: centroid_y, centroid_x, centroid_z (18 each), low_y, high_y,
  // low_x, high_x, low_z, high_z (10 each), zero fill
  output logic [vccb_pkg::M_DATA_W-1:0]       m_axis_tdata
);

  vccb_pkg::state_e state_q, state_d;
  vccb_pkg::op_e    op_q, op_d;

  logic [vccb_pkg::SIZE_W-1:0]   size_y_q, size_x_q, size_z_q;
  vccb_pkg::sizes_t              eff;

  logic [vccb_pkg::IDX_W-1:0]    idx_q;
  logic                          last_q;
  logic [vccb_pkg::SLICE_W-1:0]  slice_q;
  logic [vccb_pkg::REM_W-1:0]    rem_idx_q;
  vccb_pkg::coord_t              coord_q;
  logic [vccb_pkg::CENT_W-1:0]   cent_y_q, cent_x_q, cent_z_q;

  logic                          out_valid_q;
  logic [vccb_pkg::M_DATA_W-1:0] out_data_q;

  vccb_pkg::div_req_t            div_req;
  logic                          div_done;
  logic [vccb_pkg::DIV_W-1:0]    div_quot;
  logic [vccb_pkg::DIV_RW-1:0]   div_rem;

  vccb_pkg::acc_ctl_t            acc_ctl;
  vccb_pkg::acc_state_t          acc;

  logic                          in_fire;
  logic                          emit_fire;
  logic [vccb_pkg::DIV_W-1:0]    z_lim;
  logic [vccb_pkg::DIM_BITS-1:0] z_val;
  logic [vccb_pkg::CENT_W-1:0]   cent_val;
  logic [vccb_pkg::M_RAW_W-1:0]  out_pack;

  // Configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_y_q <= vccb_pkg::SIZE_FULL;
      size_x_q <= vccb_pkg::SIZE_FULL;
      size_z_q <= vccb_pkg::SIZE_FULL;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vccb_pkg::REG_SIZE_Y: size_y_q <= cfg_data_i;
        vccb_pkg::REG_SIZE_X: size_x_q <= cfg_data_i;
        vccb_pkg::REG_SIZE_Z: size_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff.y = vccb_pkg::eff_size(size_y_q);
    eff.x = vccb_pkg::eff_size(size_x_q);
    eff.z = vccb_pkg::eff_size(size_z_q);
  end

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign emit_fire = (state_q == vccb_pkg::ST_EMIT) && (!out_valid_q || m_axis_tready);

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      vccb_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = vccb_pkg::ST_GO;
          op_d    = vccb_pkg::OP_Z;
        end
      end
      vccb_pkg::ST_GO: state_d = vccb_pkg::ST_WAIT;
      vccb_pkg::ST_WAIT: begin
        if (div_done) begin
          unique case (op_q)
            vccb_pkg::OP_Z: begin
              op_d    = vccb_pkg::OP_X;
              state_d = vccb_pkg::ST_GO;
            end
            vccb_pkg::OP_X:  state_d = vccb_pkg::ST_UPDATE;
            vccb_pkg::OP_CY: begin
              op_d    = vccb_pkg::OP_CX;
              state_d = vccb_pkg::ST_GO;
            end
            vccb_pkg::OP_CX: begin
              op_d    = vccb_pkg::OP_CZ;
              state_d = vccb_pkg::ST_GO;
            end
            vccb_pkg::OP_CZ: state_d = vccb_pkg::ST_EMIT;
            default:         state_d = vccb_pkg::ST_IDLE;
          endcase
        end
      end
      vccb_pkg::ST_UPDATE: begin
        if (last_q) begin
          op_d    = vccb_pkg::OP_CY;
          state_d = vccb_pkg::ST_GO;
        end else begin
          state_d = vccb_pkg::ST_IDLE;
        end
      end
      vccb_pkg::ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) state_d = vccb_pkg::ST_IDLE;
      end
      default: state_d = vccb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vccb_pkg::ST_IDLE;
      op_q    <= vccb_pkg::OP_Z;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Sequencer: outputs and divider operand select
  always_comb begin
    s_axis_tready       = (state_q == vccb_pkg::ST_IDLE);
    acc_ctl.update      = (state_q == vccb_pkg::ST_UPDATE);
    acc_ctl.restart     = emit_fire;
    div_req.start       = (state_q == vccb_pkg::ST_GO);
    div_req.dividend    = '0;
    div_req.divisor     = vccb_pkg::DIV_RW'(1);
    div_req.steps       = vccb_pkg::STEP_W'(vccb_pkg::DIV_W);
    unique case (op_q)
      vccb_pkg::OP_Z: begin
        div_req.dividend = vccb_pkg::DIV_W'(idx_q) << (vccb_pkg::DIV_W - vccb_pkg::IDX_W);
        div_req.divisor  = vccb_pkg::DIV_RW'(slice_q);
        div_req.steps    = vccb_pkg::STEP_W'(vccb_pkg::IDX_W);
      end
      vccb_pkg::OP_X: begin
        div_req.dividend = vccb_pkg::DIV_W'(rem_idx_q) << (vccb_pkg::DIV_W - vccb_pkg::REM_W);
        div_req.divisor  = vccb_pkg::DIV_RW'(eff.y);
        div_req.steps    = vccb_pkg::STEP_W'(vccb_pkg::REM_W);
      end
      vccb_pkg::OP_CY: begin
        div_req.dividend = vccb_pkg::DIV_W'(acc.sum_y) << vccb_pkg::FRAC_BITS;
        div_req.divisor  = vccb_pkg::DIV_RW'(acc.count);
      end
      vccb_pkg::OP_CX: begin
        div_req.dividend = vccb_pkg::DIV_W'(acc.sum_x) << vccb_pkg::FRAC_BITS;
        div_req.divisor  = vccb_pkg::DIV_RW'(acc.count);
      end
      vccb_pkg::OP_CZ: begin
        div_req.dividend = vccb_pkg::DIV_W'(acc.sum_z) << vccb_pkg::FRAC_BITS;
        div_req.divisor  = vccb_pkg::DIV_RW'(acc.count);
      end
      default: ;
    endcase
  end

  vccb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  vccb_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (acc_ctl),
    .coord_i (coord_q),
    .sizes_i (eff),
    .acc_o   (acc)
  );

  // z clamps to the last slice; centroid saturates
  always_comb begin
    z_lim    = vccb_pkg::DIV_W'(eff.z - vccb_pkg::SIZE_W'(1));
    z_val    = (div_quot > z_lim) ? z_lim[vccb_pkg::DIM_BITS-1:0]
                                  : div_quot[vccb_pkg::DIM_BITS-1:0];
    cent_val = (|div_quot[vccb_pkg::DIV_W-1:vccb_pkg::CENT_W]) ? vccb_pkg::CENT_MAX
                                                               : div_quot[vccb_pkg::CENT_W-1:0];
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      idx_q   <= s_axis_tdata[vccb_pkg::IDX_W-1:0];
      last_q  <= s_axis_tlast;
      slice_q <= vccb_pkg::SLICE_W'(eff.y) * vccb_pkg::SLICE_W'(eff.x);
    end
    if ((state_q == vccb_pkg::ST_WAIT) && div_done) begin
      unique case (op_q)
        vccb_pkg::OP_Z: begin
          coord_q.z <= z_val;
          rem_idx_q <= div_rem[vccb_pkg::REM_W-1:0];
        end
        vccb_pkg::OP_X: begin
          coord_q.x <= div_quot[vccb_pkg::DIM_BITS-1:0];
          coord_q.y <= div_rem[vccb_pkg::DIM_BITS-1:0];
        end
        vccb_pkg::OP_CY: cent_y_q <= cent_val;
        vccb_pkg::OP_CX: cent_x_q <= cent_val;
        vccb_pkg::OP_CZ: cent_z_q <= cent_val;
        default: ;
      endcase
    end
  end

  // Output register, refilled as soon as the previous result is taken
  assign out_pack = {acc.max_z,
                     acc.min_z[vccb_pkg::DIM_BITS-1:0],
                     acc.max_x,
                     acc.min_x[vccb_pkg::DIM_BITS-1:0],
                     acc.max_y,
                     acc.min_y[vccb_pkg::DIM_BITS-1:0],
                     cent_z_q, cent_x_q, cent_y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_data_q <= vccb_pkg::M_DATA_W'(out_pack);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/core/vccb_checker.sv
`default_nettype none
`include "assert_macros.svh"

// Port-level checks for the region centroid core
module vccb_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                cfg_valid_i,
  input wire logic                                cfg_ready_o,
  input wire logic [vccb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input wire logic [vccb_pkg::SIZE_W-1:0]         cfg_data_i,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic [vccb_pkg::S_DATA_W-1:0]       s_axis_tdata,
  input wire logic                                s_axis_tlast,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [vccb_pkg::M_DATA_W-1:0]       m_axis_tdata
);

  localparam int B0 = 3 * vccb_pkg::CENT_W;
  localparam int D  = vccb_pkg::DIM_BITS;

  logic [D-1:0] lo_y, hi_y, lo_x, hi_x, lo_z, hi_z;
  logic         bounds_ok;

  always_comb begin
    lo_y = m_axis_tdata[B0 +: D];
    hi_y = m_axis_tdata[B0 + D +: D];
    lo_x = m_axis_tdata[B0 + 2 * D +: D];
    hi_x = m_axis_tdata[B0 + 3 * D +: D];
    lo_z = m_axis_tdata[B0 + 4 * D +: D];
    hi_z = m_axis_tdata[B0 + 5 * D +: D];
    bounds_ok = (lo_y <= hi_y) && (lo_x <= hi_x) && (lo_z <= hi_z);
  end

  // Config writes are never stalled
  `VCCB_ASSERT_IMP(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o)

  // One voxel in flight: a request is followed by a busy cycle
  `VCCB_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A region result always has ordered bounds
  `VCCB_ASSERT_IMP(a_bounds_order, clk_i, rst_ni, m_axis_tvalid, bounds_ok)

  // Stalled result holds
  `VCCB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind voxel_centroid_bounding_box_core vccb_checker u_vccb_checker (.*);

`default_nettype wire
